// ===== hdl/f2bcr_pkg.sv =====
// ----------------------------------------------------------------------------
// f2bcr_pkg: shared types for the GF(2) boundary column reduction unit
// Word types for both channels, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package f2bcr_pkg;

  // Fixed field widths
  localparam int unsigned ColW    = 64;
  localparam int unsigned RowOutW = 6;
  localparam int unsigned ApbDW   = 32;
  localparam int unsigned ApbAW   = 3;

  // Register index of reduction_mode (decoded from paddr[2])
  localparam logic RegModeIdx = 1'b0;

  typedef logic [RowOutW-1:0] row_out_t;

  // Input word
  typedef struct packed {
    logic [ColW-1:0] column_bits;
    logic            start_matrix;
  } f2bcr_in_t;

  // Result word
  typedef struct packed {
    logic [ColW-1:0] reduced_bits;
    row_out_t        pivot_row;
    logic            has_pivot;
    row_out_t        column_number;
    logic            overflow;
  } f2bcr_out_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_XOR,
    ST_COMMIT,
    ST_DONE
  } f2bcr_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;        // latch new column, apply start_matrix
    logic step;        // move scan to the next lower row
    logic fetch;       // read owner column for the current row
    logic apply_xor;   // fold fetched column into the working column
    logic take_pivot;  // current row becomes this column's pivot
    logic commit;      // store column, mark pivot, bump counter
    logic emit;        // load output register
  } f2bcr_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic ovf;         // column arrived with the matrix already full
    logic row_set;     // working column has the current row set
    logic row_owned;   // current row has an owner
    logic row_last;    // current row is row zero
    logic found;       // pivot already taken
    logic out_busy;    // output register still holds an untaken word
  } f2bcr_sts_t;

endpackage

// ===== hdl/f2bcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// f2bcr_ctrl: reduction sequencer
// Walks the working column from the top row down, one row per cycle, with an
// XOR state per owned row; first-pivot mode stops at a new pivot.
// ----------------------------------------------------------------------------
module f2bcr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  mode_i,
  input  f2bcr_pkg::f2bcr_sts_t sts_i,
  output f2bcr_pkg::f2bcr_cmd_t cmd_o
);

  f2bcr_pkg::f2bcr_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= f2bcr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      f2bcr_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = f2bcr_pkg::ST_SCAN;
      end
      f2bcr_pkg::ST_SCAN: begin
        priority if (sts_i.ovf) begin
          state_d = f2bcr_pkg::ST_DONE;
        end else if (sts_i.row_set && sts_i.row_owned) begin
          state_d = f2bcr_pkg::ST_XOR;
        end else if (sts_i.row_set && !sts_i.found && !mode_i) begin
          state_d = f2bcr_pkg::ST_COMMIT;
        end else if (sts_i.row_last) begin
          state_d = f2bcr_pkg::ST_COMMIT;
        end else begin
          state_d = f2bcr_pkg::ST_SCAN;
        end
      end
      f2bcr_pkg::ST_XOR: begin
        state_d = sts_i.row_last ? f2bcr_pkg::ST_COMMIT : f2bcr_pkg::ST_SCAN;
      end
      f2bcr_pkg::ST_COMMIT: begin
        state_d = f2bcr_pkg::ST_DONE;
      end
      f2bcr_pkg::ST_DONE: begin
        if (!sts_i.out_busy) state_d = f2bcr_pkg::ST_IDLE;
      end
      default: state_d = f2bcr_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      f2bcr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      f2bcr_pkg::ST_SCAN: begin
        if (!sts_i.ovf) begin
          if (sts_i.row_set && sts_i.row_owned) begin
            cmd_o.fetch = 1'b1;
          end else if (sts_i.row_set && !sts_i.found) begin
            // new pivot; exhaustive mode keeps going downward
            cmd_o.take_pivot = 1'b1;
            cmd_o.step       = mode_i && !sts_i.row_last;
          end else begin
            cmd_o.step = !sts_i.row_last;
          end
        end
      end
      f2bcr_pkg::ST_XOR: begin
        cmd_o.apply_xor = 1'b1;
        cmd_o.step      = !sts_i.row_last;
      end
      f2bcr_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
      end
      f2bcr_pkg::ST_DONE: begin
        cmd_o.emit = !sts_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== hdl/f2bcr_dpath.sv =====
// ----------------------------------------------------------------------------
// f2bcr_dpath: working column, pivot table and output register
// Reduced columns are kept in a memory indexed by their pivot row, so one
// registered read gives the owner column of a row directly.
// ----------------------------------------------------------------------------
module f2bcr_dpath #(
  parameter int unsigned MatrixSize = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  f2bcr_pkg::f2bcr_in_t  in_data_i,
  input  f2bcr_pkg::f2bcr_cmd_t cmd_i,
  output f2bcr_pkg::f2bcr_sts_t sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output f2bcr_pkg::f2bcr_out_t out_data_o
);

  localparam int unsigned RowW = (MatrixSize > 1) ? $clog2(MatrixSize) : 1;
  localparam int unsigned CntW = $clog2(MatrixSize + 1);
  localparam logic [f2bcr_pkg::ColW-1:0] RowMask =
    (MatrixSize >= f2bcr_pkg::ColW) ? '1
                                    : ((64'd1 << MatrixSize) - 64'd1);
  localparam logic [RowW-1:0] TopRow = RowW'(MatrixSize - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(MatrixSize);

  typedef logic [f2bcr_pkg::ColW-1:0] col_t;

  // Working registers
  col_t                  col_q, col_d;
  logic [RowW-1:0]       row_q, row_d;
  logic [RowW-1:0]       piv_q, piv_d;
  logic [RowW-1:0]       me_q, me_d;
  logic                  found_q, found_d;
  logic                  ovf_q, ovf_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [MatrixSize-1:0] owned_q, owned_d;
  col_t                  rd_q;
  logic                  out_valid_q, out_valid_d;
  f2bcr_pkg::f2bcr_out_t out_q, out_d;

  // Reduced columns by pivot row
  col_t pcol_mem [MatrixSize];

  logic [CntW-1:0] cnt_eff;

  // Column index after an optional matrix restart
  assign cnt_eff = in_data_i.start_matrix ? '0 : cnt_q;

  // Scan registers
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    piv_d   = piv_q;
    me_d    = me_q;
    found_d = found_q;
    ovf_d   = ovf_q;
    if (cmd_i.load) begin
      col_d   = in_data_i.column_bits & RowMask;
      row_d   = TopRow;
      found_d = 1'b0;
      ovf_d   = (cnt_eff == FullCnt);
      me_d    = cnt_eff[RowW-1:0];
    end
    if (cmd_i.apply_xor) col_d = col_q ^ rd_q;
    if (cmd_i.take_pivot) begin
      found_d = 1'b1;
      piv_d   = row_q;
    end
    if (cmd_i.step) row_d = row_q - RowW'(1);
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    row_q   <= row_d;
    piv_q   <= piv_d;
    me_q    <= me_d;
    found_q <= found_d;
    ovf_q   <= ovf_d;
  end

  // Column counter and pivot ownership bits
  always_comb begin
    cnt_d   = cnt_q;
    owned_d = owned_q;
    if (cmd_i.load && in_data_i.start_matrix) begin
      cnt_d   = '0;
      owned_d = '0;
    end
    if (cmd_i.commit) begin
      cnt_d = cnt_q + CntW'(1);
      if (found_q) owned_d[piv_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      owned_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      owned_q <= owned_d;
    end
  end

  // Column memory: write on commit, registered read of the current row
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && found_q) pcol_mem[piv_q] <= col_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) rd_q <= pcol_mem[row_q];
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      if (ovf_q) begin
        out_d.overflow = 1'b1;
      end else begin
        out_d.reduced_bits  = col_q;
        out_d.pivot_row     = found_q ? f2bcr_pkg::row_out_t'(piv_q) : '0;
        out_d.has_pivot     = found_q;
        out_d.column_number = f2bcr_pkg::row_out_t'(me_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Status
  assign sts_o.ovf       = ovf_q;
  assign sts_o.row_set   = col_q[row_q];
  assign sts_o.row_owned = owned_q[row_q];
  assign sts_o.row_last  = (row_q == '0);
  assign sts_o.found     = found_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/f2_boundary_column_reduction_unit.sv =====
// ----------------------------------------------------------------------------
// f2_boundary_column_reduction_unit: GF(2) boundary matrix column reduction
// Sequence: rows of the accepted column are scanned from the top, one row per
//   cycle, with an extra XOR state for each owned row folded in; first-pivot
//   mode stops at the new pivot. The column then passes through COMMIT and
//   DONE into the output register; an overflow column goes from SCAN to DONE.
// Flow: one column at a time; the unit is ready for the next word in the
//   cycle after the result enters the output register; a held result also stalls.
// Reset: clears pivot ownership, column counter, mode and handshake state;
//   no memory clearing pass.
// ----------------------------------------------------------------------------
module f2_boundary_column_reduction_unit #(
  parameter int unsigned MatrixSize = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  f2bcr_pkg::f2bcr_in_t            in_data_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output f2bcr_pkg::f2bcr_out_t           out_data_o,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [f2bcr_pkg::ApbAW-1:0]     paddr,
  input  logic [f2bcr_pkg::ApbDW-1:0]     pwdata,
  output logic [f2bcr_pkg::ApbDW-1:0]     prdata,
  output logic                            pready
);

  logic                  mode_q, mode_d;
  logic                  reg_hit;
  f2bcr_pkg::f2bcr_cmd_t cmd;
  f2bcr_pkg::f2bcr_sts_t sts;

  // Register decode
  assign reg_hit = (paddr[2] == f2bcr_pkg::RegModeIdx);
  assign pready  = 1'b1;

  always_comb begin
    mode_d = mode_q;
    if (psel && penable && pwrite && reg_hit) mode_d = pwdata[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign prdata = reg_hit ? {{(f2bcr_pkg::ApbDW-1){1'b0}}, mode_q} : '0;

  // Sequencer
  f2bcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_q),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  f2bcr_dpath #(
    .MatrixSize (MatrixSize)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
